// ===== src/lahd_pkg.sv =====
// Shared types, constants and register indexes of the limit alarm block.
`timescale 1ns / 1ps

package lahd_pkg;

  // Width of the millisecond time stamp; elapsed time wraps at this width.
  localparam int unsigned TIME_BITS = 48;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned HYST_BITS  = 31;
  localparam int unsigned DELAY_BITS = 27;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned LIMIT_BITS = VALUE_BITS + 1;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 32;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned S_DATA_BITS = ((VALUE_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int unsigned S_USER_BITS = 2;
  localparam int unsigned M_DATA_RAW  = 1 + COUNT_BITS + 1 + 1 + 1;
  localparam int unsigned M_DATA_BITS = ((M_DATA_RAW + 7) / 8) * 8;

  // Register reset values.
  localparam logic signed [VALUE_BITS-1:0] THRESHOLD_RESET  = 32'sd7680;
  localparam logic        [HYST_BITS-1:0]  HYSTERESIS_RESET = 31'd256;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DIRECTION_LOW   = 3'd0,
    REG_THRESHOLD       = 3'd1,
    REG_HYSTERESIS      = 3'd2,
    REG_TRIP_DELAY_MS   = 3'd3,
    REG_CLEAR_HOLD_MS   = 3'd4,
    REG_COUNTER_ENABLED = 3'd5
  } reg_index_t;

  // Item commands.
  typedef enum logic {
    CMD_EVALUATE      = 1'b0,
    CMD_COUNTER_WRITE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                          direction_low;
    logic signed [VALUE_BITS-1:0]  threshold;
    logic        [HYST_BITS-1:0]   hysteresis;
    logic        [DELAY_BITS-1:0]  trip_delay_ms;
    logic        [DELAY_BITS-1:0]  clear_hold_ms;
    logic                          counter_enabled;
  } cfg_t;

  typedef struct packed {
    logic                   active;
    logic [COUNT_BITS-1:0]  trip_count;
    logic                   pending;
    logic [TIME_BITS-1:0]   pending_since;
    logic                   stale;
  } alarm_state_t;

endpackage

// ===== src/lahd_eval.sv =====
// Next-state logic of the limit alarm for one item: compare, timing and counting.
`timescale 1ns / 1ps

module lahd_eval
  import lahd_pkg::*;
(
  input  cfg_t                         cfg,
  input  alarm_state_t                 state,
  input  logic                         cmd,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         fresh,
  input  logic [TIME_BITS-1:0]         now_ms,
  output alarm_state_t                 state_next,
  output logic                         toggled
);

  logic signed [LIMIT_BITS-1:0] value_ext;
  logic signed [LIMIT_BITS-1:0] thr_ext;
  logic signed [LIMIT_BITS-1:0] hys_ext;
  logic signed [LIMIT_BITS-1:0] limit;
  logic                         above;
  logic                         below;
  logic                         opposite;
  logic [TIME_BITS-1:0]         elapsed;
  logic [DELAY_BITS-1:0]        delay;
  logic                         expired;

  // Limit formed at 33 bits so that threshold plus or minus the band never wraps.
  always_comb begin
    value_ext = LIMIT_BITS'(value);
    thr_ext   = LIMIT_BITS'(cfg.threshold);
    hys_ext   = signed'({{(LIMIT_BITS-HYST_BITS){1'b0}}, cfg.hysteresis});
    if (!state.active) begin
      limit = thr_ext;
    end else if (cfg.direction_low) begin
      limit = thr_ext + hys_ext;
    end else begin
      limit = thr_ext - hys_ext;
    end
    above    = value_ext > limit;
    below    = value_ext < limit;
    // High direction when normal and low direction when active both look upwards.
    opposite = (cfg.direction_low ^ state.active) ? below : above;
  end

  // Time since the opposite condition began; zero when timing starts on this item.
  always_comb begin
    elapsed = state.pending ? (now_ms - state.pending_since) : '0;
    delay   = state.active ? cfg.clear_hold_ms : cfg.trip_delay_ms;
    expired = elapsed >= {{(TIME_BITS-DELAY_BITS){1'b0}}, delay};
  end

  // State update for one item.
  always_comb begin
    state_next = state;
    toggled    = 1'b0;
    unique case (cmd_t'(cmd))
      CMD_COUNTER_WRITE: begin
        if (cfg.counter_enabled && (value == '0)) begin
          state_next.trip_count = '0;
        end
      end
      CMD_EVALUATE: begin
        if (!fresh) begin
          state_next.stale   = 1'b1;
          state_next.pending = 1'b0;
        end else begin
          state_next.stale = 1'b0;
          if (!opposite) begin
            state_next.pending = 1'b0;
          end else if (expired) begin
            state_next.pending = 1'b0;
            state_next.active  = !state.active;
            toggled            = 1'b1;
            if (!state.active) begin
              state_next.trip_count = state.trip_count + 1'b1;
            end
          end else begin
            state_next.pending = 1'b1;
            if (!state.pending) begin
              state_next.pending_since = now_ms;
            end
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// ===== src/limit_alarm_hysteresis_delay.sv =====
// Path: an input register feeds one pass of compare, 48-bit elapsed-time subtract
// and counter logic into the result register. Throughput: one item per cycle
// while m_tready does not hold the result register back.
// Reset (rst, synchronous): alarm normal, count zero, nothing pending, not stale,
// configuration back to its defaults, both stages empty.
`timescale 1ns / 1ps

module limit_alarm_hysteresis_delay
  import lahd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write channel.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // Input stream.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_DATA_BITS-1:0]    s_tdata,  // value[31:0], now_ms[79:32]
  input  logic [S_USER_BITS-1:0]    s_tuser,  // cmd[0], fresh[1]
  // Result stream.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [M_DATA_BITS-1:0]    m_tdata   // alarm_active[0], trip_count[32:1],
                                              // toggled[33], is_stale[34],
                                              // change_pending[35], zeros above
);

  cfg_t                         cfg;
  alarm_state_t                 state;
  alarm_state_t                 state_next;
  logic                         toggled;
  logic                         in_valid;
  logic                         in_cmd;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         in_fresh;
  logic [TIME_BITS-1:0]         in_now_ms;
  logic                         advance;
  logic [M_DATA_BITS-1:0]       out_data_next;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction_low   <= 1'b0;
      cfg.threshold       <= THRESHOLD_RESET;
      cfg.hysteresis      <= HYSTERESIS_RESET;
      cfg.trip_delay_ms   <= '0;
      cfg.clear_hold_ms   <= '0;
      cfg.counter_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_DIRECTION_LOW:   cfg.direction_low   <= cfg_data[0];
        REG_THRESHOLD:       cfg.threshold       <= signed'(cfg_data[VALUE_BITS-1:0]);
        REG_HYSTERESIS:      cfg.hysteresis      <= cfg_data[HYST_BITS-1:0];
        REG_TRIP_DELAY_MS:   cfg.trip_delay_ms   <= cfg_data[DELAY_BITS-1:0];
        REG_CLEAR_HOLD_MS:   cfg.clear_hold_ms   <= cfg_data[DELAY_BITS-1:0];
        REG_COUNTER_ENABLED: cfg.counter_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The evaluation stage moves on when the result register is empty or being drained.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd    <= s_tuser[0];
      in_fresh  <= s_tuser[1];
      in_value  <= signed'(s_tdata[VALUE_BITS-1:0]);
      in_now_ms <= s_tdata[VALUE_BITS +: TIME_BITS];
    end
  end

  lahd_eval u_eval (
    .cfg        (cfg),
    .state      (state),
    .cmd        (in_cmd),
    .value      (in_value),
    .fresh      (in_fresh),
    .now_ms     (in_now_ms),
    .state_next (state_next),
    .toggled    (toggled)
  );

  // Alarm state, committed as each item passes into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result packing.
  always_comb begin
    out_data_next = '0;
    out_data_next[0]              = state_next.active;
    out_data_next[1 +: COUNT_BITS] = state_next.trip_count;
    out_data_next[COUNT_BITS + 1] = toggled;
    out_data_next[COUNT_BITS + 2] = state_next.stale;
    out_data_next[COUNT_BITS + 3] = state_next.pending;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= out_data_next;
    end
  end

endmodule
